// File: rtl/scg_pkg.sv
// Shared types, constants and the quarter-wave sine table for the commutation generator.
// No dependencies; imported by scg_fold, the generator core, its checker and testbench.
`default_nettype none

package scg_pkg;

  localparam int unsigned AMPLITUDE    = 200;
  localparam int unsigned MAX_STEP     = 6;
  localparam int unsigned FULL_TURN    = 360;
  localparam int unsigned HALF_TURN    = 180;
  localparam int unsigned QUARTER_TURN = 90;
  localparam int unsigned SHIFT_B      = 240;
  localparam int unsigned SHIFT_C      = 120;

  localparam int unsigned ANGLE_W = 9;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned STEP_W  = $clog2(MAX_STEP + 1);
  localparam int unsigned ADDR_W  = $clog2(QUARTER_TURN + 1);

  typedef struct packed {
    logic             forward;
    logic [7:0]       step_size;
  } scg_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic [DUTY_W-1:0]  high_a;
    logic [DUTY_W-1:0]  low_a;
    logic [DUTY_W-1:0]  high_b;
    logic [DUTY_W-1:0]  low_b;
    logic [DUTY_W-1:0]  high_c;
    logic [DUTY_W-1:0]  low_c;
  } scg_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              neg;
  } scg_fold_t;

  // trunc(200 * sin(d deg)) for d = 0..90
  function automatic logic [DUTY_W-1:0] quarter_sine(input logic [ADDR_W-1:0] d);
    logic [DUTY_W-1:0] v;
    case (d)
      7'd0:  v = 8'd0;    7'd1:  v = 8'd3;    7'd2:  v = 8'd6;    7'd3:  v = 8'd10;
      7'd4:  v = 8'd13;   7'd5:  v = 8'd17;   7'd6:  v = 8'd20;   7'd7:  v = 8'd24;
      7'd8:  v = 8'd27;   7'd9:  v = 8'd31;   7'd10: v = 8'd34;   7'd11: v = 8'd38;
      7'd12: v = 8'd41;   7'd13: v = 8'd44;   7'd14: v = 8'd48;   7'd15: v = 8'd51;
      7'd16: v = 8'd55;   7'd17: v = 8'd58;   7'd18: v = 8'd61;   7'd19: v = 8'd65;
      7'd20: v = 8'd68;   7'd21: v = 8'd71;   7'd22: v = 8'd74;   7'd23: v = 8'd78;
      7'd24: v = 8'd81;   7'd25: v = 8'd84;   7'd26: v = 8'd87;   7'd27: v = 8'd90;
      7'd28: v = 8'd93;   7'd29: v = 8'd96;   7'd30: v = 8'd100;  7'd31: v = 8'd103;
      7'd32: v = 8'd105;  7'd33: v = 8'd108;  7'd34: v = 8'd111;  7'd35: v = 8'd114;
      7'd36: v = 8'd117;  7'd37: v = 8'd120;  7'd38: v = 8'd123;  7'd39: v = 8'd125;
      7'd40: v = 8'd128;  7'd41: v = 8'd131;  7'd42: v = 8'd133;  7'd43: v = 8'd136;
      7'd44: v = 8'd138;  7'd45: v = 8'd141;  7'd46: v = 8'd143;  7'd47: v = 8'd146;
      7'd48: v = 8'd148;  7'd49: v = 8'd150;  7'd50: v = 8'd153;  7'd51: v = 8'd155;
      7'd52: v = 8'd157;  7'd53: v = 8'd159;  7'd54: v = 8'd161;  7'd55: v = 8'd163;
      7'd56: v = 8'd165;  7'd57: v = 8'd167;  7'd58: v = 8'd169;  7'd59: v = 8'd171;
      7'd60: v = 8'd173;  7'd61: v = 8'd174;  7'd62: v = 8'd176;  7'd63: v = 8'd178;
      7'd64: v = 8'd179;  7'd65: v = 8'd181;  7'd66: v = 8'd182;  7'd67: v = 8'd184;
      7'd68: v = 8'd185;  7'd69: v = 8'd186;  7'd70: v = 8'd187;  7'd71: v = 8'd189;
      7'd72: v = 8'd190;  7'd73: v = 8'd191;  7'd74: v = 8'd192;  7'd75: v = 8'd193;
      7'd76: v = 8'd194;  7'd77: v = 8'd194;  7'd78: v = 8'd195;  7'd79: v = 8'd196;
      7'd80: v = 8'd196;  7'd81: v = 8'd197;  7'd82: v = 8'd198;  7'd83: v = 8'd198;
      7'd84: v = 8'd198;  7'd85: v = 8'd199;  7'd86: v = 8'd199;  7'd87: v = 8'd199;
      7'd88: v = 8'd199;  7'd89: v = 8'd199;  7'd90: v = 8'd200;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/scg_fold.sv
// Folds a phase angle (0..359 degrees) onto the quarter-wave table: address and sign.
// Depends on scg_pkg.
`default_nettype none

module scg_fold (
  input  wire logic [scg_pkg::ANGLE_W-1:0] phase_deg,
  output scg_pkg::scg_fold_t               fold
);
  import scg_pkg::*;

  logic [ANGLE_W-1:0] idx;

  always_comb begin
    if (phase_deg <= ANGLE_W'(QUARTER_TURN)) begin
      idx      = phase_deg;
      fold.neg = 1'b0;
    end else if (phase_deg <= ANGLE_W'(HALF_TURN)) begin
      idx      = ANGLE_W'(HALF_TURN) - phase_deg;
      fold.neg = 1'b0;
    end else if (phase_deg <= ANGLE_W'(HALF_TURN + QUARTER_TURN)) begin
      idx      = phase_deg - ANGLE_W'(HALF_TURN);
      fold.neg = 1'b1;
    end else begin
      idx      = ANGLE_W'(FULL_TURN) - phase_deg;
      fold.neg = 1'b1;
    end
    fold.addr = idx[ADDR_W-1:0];
  end

endmodule

`default_nettype wire

// File: rtl/sine_commutation_generator_core.sv
// Top level of the three-phase sinusoidal commutation generator.
// Depends on scg_pkg and scg_fold.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one commutation tick request:
//   a direction bit and a step in degrees (clamped to 6). Each request moves the
//   kept electrical angle and yields one result on out_valid/out_stall/out_data:
//   the new angle (0..360) and high/low duties of three phases at 0, -120 and
//   -240 degrees, each trunc(200*sin) split by sign.
//   Pipeline: an accepted request passes through the stage-1, stage-2 and output
//   registers in turn before its result is shown on out_valid/out_data.
//   Throughput: one request per cycle while the output is not stalled;
//   the angle update loops on angle_r alone; table lookups are pipelined behind it.
//   Stall: while out_valid is high and out_stall is high the whole pipeline
//   holds and in_stall is raised; nothing is dropped.
//   Reset: rst_n low clears the angle to 0 and empties the pipeline.
`default_nettype none

module sine_commutation_generator_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire scg_pkg::scg_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output scg_pkg::scg_out_t     out_data
);
  import scg_pkg::*;

  logic               adv;
  logic               in_acc;
  logic [STEP_W-1:0]  step_sat;
  logic [ANGLE_W-1:0] angle_r;
  logic [ANGLE_W-1:0] angle_nxt;

  logic               s1_valid_r;
  logic [ANGLE_W-1:0] s1_angle_r;
  logic [ANGLE_W-1:0] base_deg;
  logic [ANGLE_W-1:0] phase_b;
  logic [ANGLE_W-1:0] phase_c;
  scg_fold_t          fold_a;
  scg_fold_t          fold_b;
  scg_fold_t          fold_c;

  logic               s2_valid_r;
  logic [ANGLE_W-1:0] s2_angle_r;
  scg_fold_t          s2_fold_a_r;
  scg_fold_t          s2_fold_b_r;
  scg_fold_t          s2_fold_c_r;

  logic [DUTY_W-1:0]  mag_a;
  logic [DUTY_W-1:0]  mag_b;
  logic [DUTY_W-1:0]  mag_c;
  scg_out_t           out_nxt;
  scg_out_t           out_data_r;
  logic               out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  assign step_sat = (in_data.step_size > 8'(MAX_STEP)) ? STEP_W'(MAX_STEP)
                                                       : in_data.step_size[STEP_W-1:0];

  always_comb begin
    if (in_data.forward) begin
      angle_nxt = (angle_r < ANGLE_W'(FULL_TURN) - ANGLE_W'(step_sat))
                ? angle_r + ANGLE_W'(step_sat) : '0;
    end else begin
      angle_nxt = (angle_r > ANGLE_W'(step_sat))
                ? angle_r - ANGLE_W'(step_sat) : ANGLE_W'(FULL_TURN) - ANGLE_W'(step_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else if (in_acc) begin
      angle_r <= angle_nxt;
    end
  end

  // Stage 1 to 2: phase angles and quadrant fold
  assign base_deg = (s1_angle_r == ANGLE_W'(FULL_TURN)) ? '0 : s1_angle_r;
  assign phase_b  = (base_deg >= ANGLE_W'(SHIFT_C)) ? base_deg - ANGLE_W'(SHIFT_C)
                                                    : base_deg + ANGLE_W'(SHIFT_B);
  assign phase_c  = (base_deg >= ANGLE_W'(SHIFT_B)) ? base_deg - ANGLE_W'(SHIFT_B)
                                                    : base_deg + ANGLE_W'(SHIFT_C);

  scg_fold u_fold_a (.phase_deg(base_deg), .fold(fold_a));
  scg_fold u_fold_b (.phase_deg(phase_b),  .fold(fold_b));
  scg_fold u_fold_c (.phase_deg(phase_c),  .fold(fold_c));

  // Stage 2 to output: table read and sign split
  assign mag_a = quarter_sine(s2_fold_a_r.addr);
  assign mag_b = quarter_sine(s2_fold_b_r.addr);
  assign mag_c = quarter_sine(s2_fold_c_r.addr);

  always_comb begin
    out_nxt.angle_deg = s2_angle_r;
    out_nxt.high_a    = s2_fold_a_r.neg ? '0 : mag_a;
    out_nxt.low_a     = s2_fold_a_r.neg ? mag_a : '0;
    out_nxt.high_b    = s2_fold_b_r.neg ? '0 : mag_b;
    out_nxt.low_b     = s2_fold_b_r.neg ? mag_b : '0;
    out_nxt.high_c    = s2_fold_c_r.neg ? '0 : mag_c;
    out_nxt.low_c     = s2_fold_c_r.neg ? mag_c : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_angle_r  <= angle_nxt;
      s2_angle_r  <= s1_angle_r;
      s2_fold_a_r <= fold_a;
      s2_fold_b_r <= fold_b;
      s2_fold_c_r <= fold_c;
      out_data_r  <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    angle_r <= ANGLE_W'(FULL_TURN))
    else $error("angle register out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(angle_r) && $stable(s1_valid_r))
    else $error("pipeline advanced while output stalled");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.high_a == '0 || out_data_r.low_a == '0) &&
                     (out_data_r.high_b == '0 || out_data_r.low_b == '0) &&
                     (out_data_r.high_c == '0 || out_data_r.low_c == '0)))
    else $error("both sides of a phase driven");

  a_angle_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r && (s1_angle_r == angle_r))
    else $error("stage one angle differs from kept angle");

endmodule

`default_nettype wire

// File: dv/commutation_checker.sv
`timescale 1ns / 1ps
// Checker for the commutation generator: watches the request and result channels,
// predicts each drive result from its own angle state and sine table, and counts mismatches.
// Depends on scg_pkg for the request and result types and the turn constants.
module commutation_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  scg_pkg::scg_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  scg_pkg::scg_out_t out_data,
  output int                mismatches,
  output int                drives_pending
);
  import scg_pkg::*;

  localparam longint unsigned PI_Q30     = 64'd3373259426;
  localparam longint unsigned ONE_Q30    = 64'd1073741824;
  localparam longint unsigned TABLE_BIAS = 64'd16384;

  logic [DUTY_W-1:0]  sine_table [0:QUARTER_TURN];
  logic [ANGLE_W-1:0] angle_q;
  scg_out_t           pending_drives[$];
  scg_out_t           next_drive;

  function automatic longint unsigned series_sine(input longint unsigned deg);
    longint unsigned x, term, sum;
    x = (deg * PI_Q30) / HALF_TURN;
    term = x;
    sum = x;
    for (longint unsigned k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum += term;
      end
    end
    return (sum > ONE_Q30) ? ONE_Q30 : sum;
  endfunction

  initial begin
    longint unsigned v;
    for (int d = 0; d <= QUARTER_TURN; d++) begin
      v = (AMPLITUDE * series_sine(64'(d)) + TABLE_BIAS) >> 30;
      sine_table[ADDR_W'(d)] = (v > AMPLITUDE) ? AMPLITUDE[DUTY_W-1:0] : v[DUTY_W-1:0];
    end
  end

  function automatic void phase_duty(input int unsigned a, output logic [DUTY_W-1:0] hi,
                                     output logic [DUTY_W-1:0] lo);
    logic [DUTY_W-1:0] mag;
    logic              neg;
    neg = (a > HALF_TURN);
    if (a <= QUARTER_TURN) begin
      mag = sine_table[ADDR_W'(a)];
    end else if (a <= HALF_TURN) begin
      mag = sine_table[ADDR_W'(HALF_TURN - a)];
    end else if (a <= HALF_TURN + QUARTER_TURN) begin
      mag = sine_table[ADDR_W'(a - HALF_TURN)];
    end else begin
      mag = sine_table[ADDR_W'(FULL_TURN - a)];
    end
    hi = neg ? '0 : mag;
    lo = neg ? mag : '0;
  endfunction

  function automatic scg_out_t predict_drive(input logic [ANGLE_W-1:0] ang, input scg_in_t req);
    scg_out_t    r;
    int unsigned s, a, base;
    s = (req.step_size > MAX_STEP) ? MAX_STEP : 32'(req.step_size);
    a = 32'(ang);
    if (req.forward) begin
      a = (a < FULL_TURN - s) ? a + s : 0;
    end else begin
      a = (a > s) ? a - s : FULL_TURN - s;
    end
    base = a % FULL_TURN;
    r.angle_deg = a[ANGLE_W-1:0];
    phase_duty(base, r.high_a, r.low_a);
    phase_duty((base + SHIFT_B) % FULL_TURN, r.high_b, r.low_b);
    phase_duty((base + SHIFT_C) % FULL_TURN, r.high_c, r.low_c);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [ANGLE_W-1:0] got,
                             input logic [ANGLE_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic compare_drive(input scg_out_t got, input scg_out_t want);
    check_field("angle_deg", got.angle_deg, want.angle_deg);
    check_field("high_a", ANGLE_W'(got.high_a), ANGLE_W'(want.high_a));
    check_field("low_a", ANGLE_W'(got.low_a), ANGLE_W'(want.low_a));
    check_field("high_b", ANGLE_W'(got.high_b), ANGLE_W'(want.high_b));
    check_field("low_b", ANGLE_W'(got.low_b), ANGLE_W'(want.low_b));
    check_field("high_c", ANGLE_W'(got.high_c), ANGLE_W'(want.high_c));
    check_field("low_c", ANGLE_W'(got.low_c), ANGLE_W'(want.low_c));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      angle_q = '0;
      pending_drives.delete();
    end else begin
      if (in_valid && !in_stall) begin
        next_drive = predict_drive(angle_q, in_data);
        pending_drives.push_back(next_drive);
        angle_q = next_drive.angle_deg;
      end
      if (out_valid && !out_stall) begin
        if (pending_drives.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          compare_drive(out_data, pending_drives.pop_front());
        end
      end
    end
    drives_pending = pending_drives.size();
  end

endmodule

// File: dv/tb_sine_commutation_generator_core.sv
`timescale 1ns / 1ps
// Testbench top for sine_commutation_generator_core: drives tick requests and result
// back-pressure in phases and gives the verdict. Depends on scg_pkg and commutation_checker.
module tb_sine_commutation_generator_core;
  import scg_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  scg_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  scg_out_t out_data;
  int       mismatches;
  int       drives_pending;
  int       idle_pct  = 0;
  int       stall_pct = 0;
  bit       long_hold = 1'b0;
  logic     heading   = 1'b1;

  sine_commutation_generator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  commutation_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatches     (mismatches),
    .drives_pending (drives_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result back-pressure; a long hold is counted here so the block fills up
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_tick(input logic fwd, input logic [7:0] step);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{forward: fwd, step_size: step};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int idle, input int stall);
    logic [7:0]  step;
    int unsigned pick;
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) begin
      if ($urandom_range(9) == 0) heading = ~heading;
      pick = $urandom_range(9);
      if (pick < 6) begin
        step = 8'($urandom_range(MAX_STEP));
      end else if (pick < 7) begin
        step = 8'd0;
      end else begin
        step = 8'($urandom_range(255));
      end
      send_tick(heading, step);
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero steps around the 0/360 seam, clamping, wrap in both directions
    send_tick(1'b1, 8'd0);
    send_tick(1'b0, 8'd0);
    send_tick(1'b0, 8'd0);
    send_tick(1'b1, 8'd0);
    send_tick(1'b0, 8'd255);
    send_tick(1'b1, 8'd6);
    send_tick(1'b1, 8'd7);
    send_tick(1'b0, 8'd6);
    send_tick(1'b1, 8'd128);
    send_tick(1'b1, 8'd1);
    send_tick(1'b0, 8'd1);
    send_tick(1'b0, 8'h55);
    send_tick(1'b1, 8'hAA);
    repeat (12) send_tick(1'b1, 8'd255);

    run_phase(240, 0, 0);
    run_phase(240, 87, 0);
    run_phase(200, 0, 87);
    run_phase(200, 34, 34);

    // hold off results while requests keep coming
    idle_pct  = 0;
    stall_pct = 0;
    long_hold = 1'b1;
    run_phase(40, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (drives_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
